// ===== design/wfhb_pkg.sv =====
// Shared types and constants of the weighted frame history blender.
// No dependencies; imported by every module of the block.
package wfhb_pkg;

  localparam int unsigned FramePixBits = 16;
  localparam int unsigned SlotBits     = 3;
  localparam int unsigned AddrBits     = SlotBits + FramePixBits;
  localparam int unsigned WeightFrac   = 4;
  localparam int unsigned SumBits      = 15;
  localparam int unsigned TotalBits    = 11;
  localparam int unsigned DivdBits     = SumBits + WeightFrac;
  localparam int unsigned DivStepBits  = 5;

  localparam logic [3:0]  HistMin      = 4'd2;
  localparam logic [3:0]  HistMax      = 4'd8;
  localparam logic [63:0] WeightReset  = 64'h1010_1010_1010_1010;
  localparam logic [7:0]  ByteMax      = 8'hFF;

  localparam logic [1:0] OpPush   = 2'd0;
  localparam logic [1:0] OpBlend  = 2'd1;
  localparam logic [1:0] OpStored = 2'd2;
  localparam logic [1:0] OpIgnore = 2'd3;

  localparam logic [1:0] CfgHistSize = 2'd0;
  localparam logic [1:0] CfgBlendEn  = 2'd1;
  localparam logic [1:0] CfgWeights  = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoFrame = 2'd1;
  localparam logic [1:0] StatZeroWgt = 2'd2;

  typedef struct packed {
    logic                en;
    logic [AddrBits-1:0] addr;
    logic [31:0]         data;
  } wfhb_wr_t;

  typedef struct packed {
    logic                 start;
    logic [DivdBits-1:0]  dividend;
    logic [TotalBits-1:0] divisor;
  } wfhb_div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivdBits-1:0] quotient;
  } wfhb_div_rsp_t;

endpackage

// ===== design/wfhb_store.sv =====
// Frame store: one write port and one registered read port.
// Depends on wfhb_pkg for address width and write request type.
module wfhb_store (
  input  logic                       clk_i,
  input  wfhb_pkg::wfhb_wr_t         wr_i,
  input  logic                       rd_en_i,
  input  logic [wfhb_pkg::AddrBits-1:0] rd_addr_i,
  output logic [31:0]                rd_data_o
);
  import wfhb_pkg::*;

  logic [31:0] mem_q [2**AddrBits];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/wfhb_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on wfhb_pkg for operand widths and request/response types.
module wfhb_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wfhb_pkg::wfhb_div_req_t req_i,
  output wfhb_pkg::wfhb_div_rsp_t rsp_o
);
  import wfhb_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DivStepBits-1:0] step_q, step_d;
  logic [DivdBits-1:0]    dq_q, dq_d;
  logic [TotalBits-1:0]   rem_q, rem_d;
  logic [TotalBits-1:0]   dvs_q, dvs_d;
  logic [TotalBits:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dq_q[DivdBits-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = TotalBits'(trial - {1'b0, dvs_q});
        dq_d  = {dq_q[DivdBits-2:0], 1'b1};
      end else begin
        rem_d = trial[TotalBits-1:0];
        dq_d  = {dq_q[DivdBits-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == DivStepBits'(DivdBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

// ===== design/weighted_frame_history_blender.sv =====
// Top level of the weighted frame history blender: sequencer, ring state,
// registers and output stage. Depends on wfhb_pkg, wfhb_store, wfhb_divider.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: a push, a
//   blended read or a stored read. Output channel (out_valid_o / out_stall_i)
//   returns one result per read; pushes and op three return nothing.
//   Configuration writes (cfg_valid_i / cfg_ready_o) set history size, blend
//   enable and the weight table; issue them only while the block is idle.
// Sequence:
//   A push is written to the store when it is taken; the block stays idle.
//   A stored read steps through StRead, StAcc and StResp; a read that finds
//   no frame goes straight to StResp. A blended read does one store read and
//   accumulation (StRead, StAcc) per held frame, then four serial divisions
//   (StDivS, StDivW) through the one shared divider, then StResp. The store
//   read port and the divider set the length of each read.
// Reset: ring head and frame count clear, history size 2, blending off,
//   all weights 1.0. The frame store is not cleared.
// Stall: a finished result waits in the output register; the block takes a
//   new request meanwhile and holds the next result until the register frees.
module weighted_frame_history_blender (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic        start_of_frame_i,
  input  logic [15:0] pixel_index_i,
  input  logic [31:0] pixel_value_i,
  input  logic [2:0]  frame_age_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_out_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import wfhb_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StRead = 6'b000010,
    StAcc  = 6'b000100,
    StDivS = 6'b001000,
    StDivW = 6'b010000,
    StResp = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration and ring state
  logic [3:0]          hist_q, hist_d;
  logic                blend_q, blend_d;
  logic [63:0]         wgt_q, wgt_d;
  logic [SlotBits-1:0] head_q, head_d;
  logic [3:0]          held_q, held_d;

  // request in flight
  logic [FramePixBits-1:0] pix_q, pix_d;
  logic [SlotBits-1:0]     age_q, age_d;
  logic                    single_q, single_d;
  logic [1:0]              ch_q, ch_d;
  logic [SumBits-1:0]      sum_q [4];
  logic [SumBits-1:0]      sum_d [4];
  logic [TotalBits-1:0]    total_q, total_d;
  logic [31:0]             res_q, res_d;
  logic [1:0]              stat_q, stat_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_pix_q, out_pix_d;
  logic [1:0]  out_stat_q, out_stat_d;

  logic                in_acc;
  logic [SlotBits-1:0] push_head;
  logic [3:0]          push_held;
  logic [SlotBits-1:0] want;
  logic [3:0]          slot_wide;
  logic [SlotBits-1:0] rd_slot;
  logic [7:0]          wgt_cur;
  logic [TotalBits-1:0] total_nx;
  logic [15:0]         prod [4];
  logic [31:0]         rd_data;
  logic                out_free;
  logic [7:0]          quo_byte;
  wfhb_wr_t            wr;
  wfhb_div_req_t       div_req;
  wfhb_div_rsp_t       div_rsp;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // next head and count for a push
  always_comb begin
    push_head = head_q;
    push_held = held_q;
    if (start_of_frame_i) begin
      push_head = ({1'b0, head_q} + 4'd1 == hist_q) ? '0 : head_q + 1'b1;
      if (held_q < hist_q) begin
        push_held = held_q + 4'd1;
      end
    end
  end

  assign want = (op_i == OpBlend) ? '0 : frame_age_i;

  // ring slot of the frame at age_q
  always_comb begin
    if (head_q >= age_q) begin
      slot_wide = {1'b0, head_q} - {1'b0, age_q};
    end else begin
      slot_wide = {1'b0, head_q} + hist_q - {1'b0, age_q};
    end
  end
  assign rd_slot = slot_wide[SlotBits-1:0];

  assign wgt_cur  = wgt_q[{age_q, 3'b000} +: 8];
  assign total_nx = total_q + TotalBits'(wgt_cur);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c] = rd_data[8*c +: 8] * wgt_cur;
    end
  end

  // clamp the quotient to one byte
  assign quo_byte = (|div_rsp.quotient[DivdBits-1:8]) ? ByteMax : div_rsp.quotient[7:0];

  always_comb begin
    state_d     = state_q;
    hist_d      = hist_q;
    blend_d     = blend_q;
    wgt_d       = wgt_q;
    head_d      = head_q;
    held_d      = held_q;
    pix_d       = pix_q;
    age_d       = age_q;
    single_d    = single_q;
    ch_d        = ch_q;
    sum_d       = sum_q;
    total_d     = total_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_stat_d  = out_stat_q;
    wr.en       = 1'b0;
    wr.addr     = {push_head, pixel_index_i};
    wr.data     = pixel_value_i;
    div_req.start    = 1'b0;
    div_req.dividend = {sum_q[ch_q], {WeightFrac{1'b0}}};
    div_req.divisor  = total_q;

    // drop the held result once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHistSize: begin
          if (cfg_data_i[3:0] < HistMin) begin
            hist_d = HistMin;
          end else if (cfg_data_i[3:0] > HistMax) begin
            hist_d = HistMax;
          end else begin
            hist_d = cfg_data_i[3:0];
          end
          head_d = '0;
          held_d = '0;
        end
        CfgBlendEn: blend_d = cfg_data_i[0];
        CfgWeights: wgt_d   = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          pix_d = pixel_index_i;
          case (op_i)
            OpPush: begin
              head_d = push_head;
              held_d = push_held;
              wr.en  = 1'b1;
            end
            OpBlend, OpStored: begin
              res_d  = '0;
              stat_d = StatOk;
              if (op_i == OpBlend && blend_q && held_q >= 4'd2) begin
                single_d = 1'b0;
                age_d    = '0;
                total_d  = '0;
                for (int c = 0; c < 4; c++) begin
                  sum_d[c] = '0;
                end
                state_d = StRead;
              end else if ({1'b0, want} >= held_q) begin
                stat_d  = StatNoFrame;
                state_d = StResp;
              end else begin
                single_d = 1'b1;
                age_d    = want;
                state_d  = StRead;
              end
            end
            default: ;
          endcase
        end
      end
      StRead: state_d = StAcc;
      StAcc: begin
        if (single_q) begin
          res_d   = rd_data;
          state_d = StResp;
        end else begin
          total_d = total_nx;
          for (int c = 0; c < 4; c++) begin
            sum_d[c] = sum_q[c] + SumBits'(prod[c][15:WeightFrac]);
          end
          if ({1'b0, age_q} + 4'd1 == held_q) begin
            if (total_nx == '0) begin
              stat_d  = StatZeroWgt;
              state_d = StResp;
            end else begin
              ch_d    = '0;
              state_d = StDivS;
            end
          end else begin
            age_d   = age_q + 1'b1;
            state_d = StRead;
          end
        end
      end
      StDivS: begin
        div_req.start = 1'b1;
        state_d       = StDivW;
      end
      StDivW: begin
        if (div_rsp.done) begin
          res_d[8*ch_q +: 8] = quo_byte;
          if (ch_q == 2'd3) begin
            state_d = StResp;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = StDivS;
          end
        end
      end
      StResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = res_q;
          out_stat_d  = stat_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hist_q      <= HistMin;
      blend_q     <= 1'b0;
      wgt_q       <= WeightReset;
      head_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hist_q      <= hist_d;
      blend_q     <= blend_d;
      wgt_q       <= wgt_d;
      head_q      <= head_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    age_q      <= age_d;
    single_q   <= single_d;
    ch_q       <= ch_d;
    sum_q      <= sum_d;
    total_q    <= total_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_pix_q  <= out_pix_d;
    out_stat_q <= out_stat_d;
  end

  wfhb_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (state_q == StRead),
    .rd_addr_i ({rd_slot, pix_q}),
    .rd_data_o (rd_data)
  );

  wfhb_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign status_o    = out_stat_q;

`ifndef NO_ASSERTIONS
  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= hist_q) else $error("frame count exceeds history size");

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < hist_q) else $error("head slot outside ring");

  a_blend_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAcc && !single_q) |-> (held_q >= 4'd2 && blend_q))
    else $error("blend accumulation with fewer than two frames");

  a_div_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == StDivW) else $error("divider result unexpected");
`endif

endmodule

// ===== bench/tb_weighted_frame_history_blender.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the weighted frame history blender: random and
// directed pushes and reads, scored against an in-bench ring predictor.
// Depends on wfhb_pkg and the weighted_frame_history_blender RTL only.

class blend_scoreboard;
  // mirror of the ring; only written entries are ever read back
  logic [31:0] pix_mem [int unsigned];
  int unsigned head;
  int unsigned held;
  int unsigned hist;
  bit          blend_on;
  logic [63:0] weights;
  logic [31:0] want_pix [$];
  logic [1:0]  want_stat [$];
  int unsigned errors;
  int unsigned checked;

  function new();
    head = 0; held = 0; hist = 2; blend_on = 0;
    weights = wfhb_pkg::WeightReset;
    errors = 0; checked = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [63:0] data);
    int unsigned v;
    v = data[3:0];
    if (idx == wfhb_pkg::CfgHistSize) begin
      if (v < 2) v = 2;
      if (v > 8) v = 8;
      hist = v; head = 0; held = 0;
    end else if (idx == wfhb_pkg::CfgBlendEn) begin
      blend_on = data[0];
    end else if (idx == wfhb_pkg::CfgWeights) begin
      weights = data;
    end
  endfunction

  function logic [31:0] pix_at(int unsigned age, logic [15:0] pix);
    int unsigned slot;
    int unsigned key;
    slot = (head + hist - age) % hist;
    key = slot * 65536 + pix;
    if (pix_mem.exists(key)) return pix_mem[key];
    return '0;
  endfunction

  // note an accepted request, queue its expected result if any
  function void note_request(logic [1:0] op, logic sof, logic [15:0] pix,
                             logic [31:0] val, logic [2:0] age);
    logic [63:0] sum [4];
    logic [63:0] total;
    logic [63:0] q;
    logic [31:0] res;
    logic [31:0] p;
    logic [7:0]  w;
    logic [1:0]  st;
    int unsigned want;
    res = '0; st = wfhb_pkg::StatOk;
    if (op == wfhb_pkg::OpPush) begin
      if (sof) begin
        head = (head + 1) % hist;
        if (held < hist) held++;
      end
      pix_mem[head * 65536 + pix] = val;
      return;
    end
    if (op == wfhb_pkg::OpIgnore) return;
    if (op == wfhb_pkg::OpBlend && blend_on && held >= 2) begin
      for (int c = 0; c < 4; c++) sum[c] = 0;
      total = 0;
      for (int i = 0; i < held; i++) begin
        w = weights[8*i +: 8];
        p = pix_at(i, pix);
        total += w;
        for (int c = 0; c < 4; c++) sum[c] += (64'(p[8*c +: 8]) * w) >> 4;
      end
      if (total == 0) begin
        st = wfhb_pkg::StatZeroWgt;
      end else begin
        for (int c = 0; c < 4; c++) begin
          q = (sum[c] << 4) / total;
          if (q > 255) q = 255;
          res[8*c +: 8] = q[7:0];
        end
      end
    end else begin
      want = (op == wfhb_pkg::OpBlend) ? 0 : age;
      if (want >= held) st = wfhb_pkg::StatNoFrame;
      else res = pix_at(want, pix);
    end
    want_pix.push_back(res);
    want_stat.push_back(st);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endfunction

  function void check_result(logic [31:0] pix, logic [1:0] st);
    logic [31:0] ep;
    logic [1:0]  es;
    checked++;
    if (want_pix.size() == 0) begin
      report("unexpected result", pix, '0);
      return;
    end
    ep = want_pix.pop_front();
    es = want_stat.pop_front();
    if (pix !== ep) report("pixel_out", pix, ep);
    if (st !== es) report("status", 32'(st), 32'(es));
  endfunction
endclass

module tb_weighted_frame_history_blender;
  import wfhb_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic        start_of_frame_i = 0;
  logic [15:0] pixel_index_i = '0;
  logic [31:0] pixel_value_i = '0;
  logic [2:0]  frame_age_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [31:0] pixel_out_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  blend_scoreboard ring_sb = new();

  // idle percentages, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent = 0;
  // pixel indexes written in every held frame are pooled to avoid unwritten reads
  logic [15:0] pix_pool [$];

  always #5 clk_i = ~clk_i;

  weighted_frame_history_blender dut (.*);

  // sample results at the rising edge; drive stall at the falling edge
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) ring_sb.check_result(pixel_out_o, status_o);
  end

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_stall_i <= 1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: count cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || hold_off_cycles > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("tb_weighted_frame_history_blender: errors");
      $finish;
    end
  end

  // send one request, holding it until the block takes it; valid drops
  // only when the sender idles or pauses
  task automatic send_request(logic [1:0] op, logic sof, logic [15:0] pix,
                              logic [31:0] val, logic [2:0] age);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    op_i <= op; start_of_frame_i <= sof; pixel_index_i <= pix;
    pixel_value_i <= val; frame_age_i <= age;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ring_sb.note_request(op, sof, pix, val, age);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // drain outstanding results, then let a blend still in flight finish
  task automatic wait_drained();
    in_valid_i <= 0;
    while (ring_sb.want_pix.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    wait_drained();
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ring_sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    // history write clears the ring: written indexes no longer trusted
    if (idx == CfgHistSize) pix_pool.delete();
  endtask

  // one frame: start-of-frame push, fill every pooled index, then extra new ones
  task automatic push_frame(int unsigned extra);
    logic [15:0] p;
    p = pix_pool.size() ? pix_pool[0] : 16'($urandom);
    if (pix_pool.size() == 0) pix_pool.push_back(p);
    send_request(OpPush, 1'b1, p, $urandom, 3'($urandom));
    for (int i = 1; i < pix_pool.size(); i++)
      send_request(OpPush, 1'b0, pix_pool[i], $urandom, 3'($urandom));
    for (int i = 0; i < extra; i++) begin
      p = 16'($urandom);
      // an extra index is written to this frame only and never joins the pool
      send_request(OpPush, 1'b0, p, $urandom, 3'($urandom));
    end
  endtask

  // a read chosen so it never touches an unwritten entry
  task automatic random_read();
    logic [15:0] p;
    logic [2:0]  age;
    p = pix_pool[$urandom_range(pix_pool.size() - 1)];
    age = 3'($urandom);
    if ($urandom_range(1)) send_request(OpBlend, 1'($urandom), p, $urandom, age);
    else send_request(OpStored, 1'($urandom), p, $urandom, age);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 12) push_frame($urandom_range(2));
      else if (k < 20) send_request(OpPush, 1'b0,
                                    pix_pool[$urandom_range(pix_pool.size() - 1)],
                                    $urandom, 3'($urandom));
      else if (k < 23) send_request(OpIgnore, 1'($urandom), 16'($urandom), $urandom,
                                    3'($urandom));
      else random_read();
    end
  endtask

  initial begin
    logic [63:0] wt;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty reads, first frames, extremes of fields
    pix_pool.push_back(16'hFFFF);
    pix_pool.push_back(16'h0000);
    send_request(OpBlend, 0, 16'hFFFF, 0, 0);
    send_request(OpStored, 1, 16'h0000, 0, 3'd7);
    send_request(OpPush, 0, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
    send_request(OpPush, 0, 16'h0000, 32'h0000_0000, 0);
    send_request(OpStored, 0, 16'hFFFF, 0, 0);
    send_request(OpIgnore, 1, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
    push_frame(0);
    send_request(OpStored, 0, 16'hFFFF, 0, 0);
    send_request(OpBlend, 0, 16'h0000, 0, 0);
    write_reg(CfgBlendEn, 64'd1);
    push_frame(0);
    push_frame(0);
    send_request(OpBlend, 0, 16'hFFFF, 0, 0);
    send_request(OpStored, 0, 16'h0000, 0, 3'd1);
    send_request(OpStored, 0, 16'h0000, 0, 3'd2);
    write_reg(CfgWeights, 64'd0);
    send_request(OpBlend, 0, 16'hFFFF, 0, 0);
    write_reg(CfgWeights, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OpBlend, 0, 16'h0000, 0, 0);

    // random phases over several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 37; recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(CfgHistSize, (ph == 0) ? 64'd8 : (ph == 1) ? 64'd0 :
                (ph == 2) ? 64'hF : 64'($urandom_range(2, 8)));
      write_reg(CfgBlendEn, (ph == 4) ? 64'd0 : 64'd1);
      wt = {$urandom, $urandom};
      if (ph == 3) wt = 64'hFFFF_FFFF_FFFF_FFFF;
      if (ph == 5) wt = 64'h0000_0000_0000_00FF;
      write_reg(CfgWeights, wt);
      pix_pool.push_back(16'($urandom));
      pix_pool.push_back(16'($urandom));
      for (int f = 0; f < 9; f++) push_frame(0);
      if (ph == 2) begin
        // long receiver hold-off while requests keep coming
        hold_off_cycles = 1500;
        for (int i = 0; i < 12; i++) random_read();
        wait_drained();
      end
      random_phase(70);
    end
    wait_drained();
    $display("covered %0d requests and %0d results over six settings",
             requests_sent, ring_sb.checked);
    if (ring_sb.errors == 0 && ring_sb.want_pix.size() == 0)
      $display("tb_weighted_frame_history_blender: clean");
    else
      $display("tb_weighted_frame_history_blender: errors");
    $finish;
  end
endmodule
